// ===== design/csc_pkg.sv =====
// shared types, codes and sizes for the csr to csc transpose block
// no dependencies
`timescale 1ns / 1ps

package csc_pkg;

  localparam int MAX_ENTRIES = 4096;
  localparam int MAX_COLUMNS = 1024;
  localparam int MAX_ROWS    = 1024;

  localparam int ENTRY_W = $clog2(MAX_ENTRIES);
  localparam int COUNT_W = ENTRY_W + 1;
  localparam int COL_W   = $clog2(MAX_COLUMNS);
  localparam int ROW_W   = $clog2(MAX_ROWS);
  localparam int CFG_W   = 11;

  localparam logic [1:0] OP_LOAD       = 2'd0;
  localparam logic [1:0] OP_READ_ENTRY = 2'd1;
  localparam logic [1:0] OP_READ_END   = 2'd2;
  localparam logic [1:0] OP_NONE       = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_READY = 2'd1;
  localparam logic [1:0] ST_BAD_LOAD  = 2'd2;

  localparam logic [1:0] REG_NUM_COLUMNS = 2'd0;
  localparam logic [1:0] REG_NUM_ROWS    = 2'd1;

  typedef struct packed {
    logic [1:0]  operation;
    logic [9:0]  row;
    logic [9:0]  column;
    logic [63:0] value;
    logic        last;
    logic [11:0] index;
  } in_t;

  typedef struct packed {
    logic [9:0]  out_row;
    logic [63:0] out_value;
    logic [12:0] column_end;
    logic [1:0]  status;
  } out_t;

  // classified command between front and back
  typedef struct packed {
    logic [1:0]  op;
    logic [9:0]  row;
    logic [9:0]  column;
    logic [63:0] value;
    logic        last;
    logic [11:0] index;
    logic        load_bad;
    logic        col_bad;
  } cmd_t;

endpackage

// ===== design/csc_fifo.sv =====
// short command queue between the front and the back
// depends on csc_pkg
`timescale 1ns / 1ps

module csc_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  csc_pkg::cmd_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output csc_pkg::cmd_t pop_data_o
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  csc_pkg::cmd_t     mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [PTR_W:0]    cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o     = (cnt_q == (PTR_W+1)'(DEPTH));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_d  = do_push ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

// ===== design/csc_front.sv =====
// front end: config registers, input acceptance and range classification
// depends on csc_pkg
`timescale 1ns / 1ps

module csc_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  csc_pkg::in_t              in_data_i,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_index_i,
  input  logic [csc_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                      q_full_i,
  output logic                      q_push_o,
  output csc_pkg::cmd_t             q_data_o
);

  logic [csc_pkg::CFG_W-1:0] num_columns_q, num_rows_q;
  logic                      row_bad, col_bad;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_columns_q <= csc_pkg::CFG_W'(csc_pkg::MAX_COLUMNS);
      num_rows_q    <= csc_pkg::CFG_W'(csc_pkg::MAX_ROWS);
    end else if (cfg_we_i) begin
      if (cfg_index_i == csc_pkg::REG_NUM_COLUMNS) begin
        num_columns_q <= cfg_data_i;
      end else if (cfg_index_i == csc_pkg::REG_NUM_ROWS) begin
        num_rows_q <= cfg_data_i;
      end
    end
  end

  // fields are narrower than the max sizes, so only the registers limit
  assign row_bad = ({1'b0, in_data_i.row} >= num_rows_q);
  assign col_bad = ({1'b0, in_data_i.column} >= num_columns_q);

  assign in_stall_o = q_full_i;
  // unused operation is accepted and dropped here
  assign q_push_o   = in_valid_i && !q_full_i && (in_data_i.operation != csc_pkg::OP_NONE);

  always_comb begin
    q_data_o.op       = in_data_i.operation;
    q_data_o.row      = in_data_i.row;
    q_data_o.column   = in_data_i.column;
    q_data_o.value    = in_data_i.value;
    q_data_o.last     = in_data_i.last;
    q_data_o.index    = in_data_i.index;
    q_data_o.load_bad = row_bad || col_bad;
    q_data_o.col_bad  = col_bad;
  end

endmodule

// ===== design/csc_back.sv =====
// back end: entry stores, count / prefix / scatter sequencer, reads, result register
// depends on csc_pkg
`timescale 1ns / 1ps

module csc_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  csc_pkg::cmd_t q_data_i,
  output logic          q_pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output csc_pkg::out_t out_data_o
);

  localparam int EW = csc_pkg::ENTRY_W;
  localparam int CW = csc_pkg::COUNT_W;
  localparam int KW = csc_pkg::COL_W;
  localparam int RW = csc_pkg::ROW_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RWAIT = 3'd1;
  localparam logic [2:0] S_CLEAR = 3'd2;
  localparam logic [2:0] S_CNT   = 3'd3;
  localparam logic [2:0] S_PRE   = 3'd4;
  localparam logic [2:0] S_SCAT  = 3'd5;

  typedef struct packed {
    logic [RW-1:0] row;
    logic [KW-1:0] column;
    logic [63:0]   value;
  } ld_t;

  typedef struct packed {
    logic [RW-1:0] row;
    logic [63:0]   value;
  } tr_t;

  // memories
  ld_t           ld_mem [csc_pkg::MAX_ENTRIES];
  tr_t           tr_mem [csc_pkg::MAX_ENTRIES];
  logic [CW-1:0] cnt_mem [csc_pkg::MAX_COLUMNS];
  logic [CW-1:0] fill_mem [csc_pkg::MAX_COLUMNS];
  logic [CW-1:0] end_mem [csc_pkg::MAX_COLUMNS];

  logic          ld_we, ld_re, tr_we, tr_re;
  logic [EW-1:0] ld_waddr, ld_raddr, tr_waddr, tr_raddr;
  ld_t           ld_wdata, ld_rdata_q;
  tr_t           tr_wdata, tr_rdata_q;
  logic          cnt_we, cnt_re, fill_we, fill_re, end_we, end_re;
  logic [KW-1:0] cnt_waddr, cnt_raddr, fill_waddr, fill_raddr, end_waddr, end_raddr;
  logic [CW-1:0] cnt_wdata, fill_wdata, end_wdata;
  logic [CW-1:0] cnt_rdata_q, fill_rdata_q, end_rdata_q;

  logic [2:0]    state_q, state_d;
  logic [1:0]    ph_q, ph_d;
  logic [CW-1:0] ec_q, ec_d, k_q, k_d, sum_q, sum_d, ec_eff;
  logic [KW-1:0] ctr_q, ctr_d;
  logic          done_q, done_d;
  logic [1:0]    rd_op_q, rd_op_d;
  logic          out_valid_q, out_valid_d, out_free, produce, bad;
  csc_pkg::out_t out_q, out_d;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign q_pop_o     = (state_q == S_IDLE) && q_valid_i && out_free;

  always_comb begin
    state_d = state_q;
    ph_d    = ph_q;
    ec_d    = ec_q;
    k_d     = k_q;
    sum_d   = sum_q;
    ctr_d   = ctr_q;
    done_d  = done_q;
    rd_op_d = rd_op_q;
    produce = 1'b0;
    out_d   = '0;
    ec_eff  = done_q ? '0 : ec_q;
    bad     = q_data_i.load_bad || (ec_eff == CW'(csc_pkg::MAX_ENTRIES));

    ld_we = 1'b0; ld_waddr = ec_eff[EW-1:0];
    ld_wdata = '{row: q_data_i.row, column: q_data_i.column, value: q_data_i.value};
    ld_re = 1'b0; ld_raddr = k_q[EW-1:0];
    tr_we = 1'b0; tr_waddr = fill_rdata_q[EW-1:0];
    tr_wdata = '{row: ld_rdata_q.row, value: ld_rdata_q.value};
    tr_re = 1'b0; tr_raddr = q_data_i.index;
    cnt_we = 1'b0; cnt_waddr = ctr_q; cnt_wdata = '0;
    cnt_re = 1'b0; cnt_raddr = ctr_q;
    fill_we = 1'b0; fill_waddr = ctr_q; fill_wdata = sum_q;
    fill_re = 1'b0; fill_raddr = ld_rdata_q.column;
    end_we = 1'b0; end_waddr = ctr_q; end_wdata = sum_q + cnt_rdata_q;
    end_re = 1'b0; end_raddr = q_data_i.column;

    case (state_q)
      S_IDLE: begin
        if (q_pop_o) begin
          case (q_data_i.op)
            csc_pkg::OP_LOAD: begin
              done_d  = 1'b0;
              produce = 1'b1;
              if (bad) begin
                out_d.status = csc_pkg::ST_BAD_LOAD;
                ec_d         = ec_eff;
              end else begin
                ld_we = 1'b1;
                ec_d  = ec_eff + 1'b1;
              end
              if (q_data_i.last) begin
                state_d = S_CLEAR;
                ctr_d   = '0;
              end
            end
            csc_pkg::OP_READ_ENTRY: begin
              if (!done_q || ({1'b0, q_data_i.index} >= ec_q)) begin
                produce      = 1'b1;
                out_d.status = csc_pkg::ST_NOT_READY;
              end else begin
                tr_re   = 1'b1;
                rd_op_d = q_data_i.op;
                state_d = S_RWAIT;
              end
            end
            csc_pkg::OP_READ_END: begin
              if (!done_q || q_data_i.col_bad) begin
                produce      = 1'b1;
                out_d.status = csc_pkg::ST_NOT_READY;
              end else begin
                end_re  = 1'b1;
                rd_op_d = q_data_i.op;
                state_d = S_RWAIT;
              end
            end
            default: ;
          endcase
        end
      end
      S_RWAIT: begin
        if (out_free) begin
          produce = 1'b1;
          state_d = S_IDLE;
          if (rd_op_q == csc_pkg::OP_READ_ENTRY) begin
            out_d.out_row   = tr_rdata_q.row;
            out_d.out_value = tr_rdata_q.value;
          end else begin
            out_d.column_end = end_rdata_q;
          end
        end
      end
      S_CLEAR: begin
        cnt_we = 1'b1;
        ctr_d  = ctr_q + 1'b1;
        if (ctr_q == KW'(csc_pkg::MAX_COLUMNS - 1)) begin
          state_d = S_CNT;
          k_d     = '0;
          ph_d    = 2'd0;
        end
      end
      S_CNT: begin
        case (ph_q)
          2'd0: begin
            if (k_q == ec_q) begin
              state_d = S_PRE;
              ctr_d   = '0;
              sum_d   = '0;
            end else begin
              ld_re = 1'b1;
              ph_d  = 2'd1;
            end
          end
          2'd1: begin
            cnt_re    = 1'b1;
            cnt_raddr = ld_rdata_q.column;
            ph_d      = 2'd2;
          end
          default: begin
            cnt_we    = 1'b1;
            cnt_waddr = ld_rdata_q.column;
            cnt_wdata = cnt_rdata_q + 1'b1;
            k_d       = k_q + 1'b1;
            ph_d      = 2'd0;
          end
        endcase
      end
      S_PRE: begin
        if (ph_q == 2'd0) begin
          cnt_re = 1'b1;
          ph_d   = 2'd1;
        end else begin
          // fill pointer takes the running sum before this column
          fill_we = 1'b1;
          end_we  = 1'b1;
          sum_d   = end_wdata;
          ph_d    = 2'd0;
          ctr_d   = ctr_q + 1'b1;
          if (ctr_q == KW'(csc_pkg::MAX_COLUMNS - 1)) begin
            state_d = S_SCAT;
            k_d     = '0;
          end
        end
      end
      S_SCAT: begin
        case (ph_q)
          2'd0: begin
            if (k_q == ec_q) begin
              state_d = S_IDLE;
              done_d  = 1'b1;
            end else begin
              ld_re = 1'b1;
              ph_d  = 2'd1;
            end
          end
          2'd1: begin
            fill_re = 1'b1;
            ph_d    = 2'd2;
          end
          default: begin
            tr_we      = 1'b1;
            fill_we    = 1'b1;
            fill_waddr = ld_rdata_q.column;
            fill_wdata = fill_rdata_q + 1'b1;
            k_d        = k_q + 1'b1;
            ph_d       = 2'd0;
          end
        endcase
      end
      default: state_d = S_IDLE;
    endcase

    out_valid_d = produce ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ph_q        <= '0;
      ec_q        <= '0;
      k_q         <= '0;
      sum_q       <= '0;
      ctr_q       <= '0;
      done_q      <= 1'b0;
      rd_op_q     <= csc_pkg::OP_NONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ph_q        <= ph_d;
      ec_q        <= ec_d;
      k_q         <= k_d;
      sum_q       <= sum_d;
      ctr_q       <= ctr_d;
      done_q      <= done_d;
      rd_op_q     <= rd_op_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (produce) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_we) ld_mem[ld_waddr] <= ld_wdata;
    if (ld_re) ld_rdata_q <= ld_mem[ld_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (tr_we) tr_mem[tr_waddr] <= tr_wdata;
    if (tr_re) tr_rdata_q <= tr_mem[tr_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    if (cnt_re) cnt_rdata_q <= cnt_mem[cnt_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (fill_we) fill_mem[fill_waddr] <= fill_wdata;
    if (fill_re) fill_rdata_q <= fill_mem[fill_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (end_we) end_mem[end_waddr] <= end_wdata;
    if (end_re) end_rdata_q <= end_mem[end_raddr];
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ec_q <= CW'(csc_pkg::MAX_ENTRIES))
    else $error("entry count above store depth");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    produce |-> out_free)
    else $error("result written while held result is stalled");

  a_scatter_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAT && ph_q == 2'd2) |-> (fill_rdata_q < ec_q))
    else $error("scatter position beyond entry count");

  a_busy_no_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !q_pop_o)
    else $error("command taken while sequencer busy");

endmodule

// ===== design/csr_to_csc_transpose_top.sv =====
// top level of the sparse csr to csc transpose block
// depends on csc_pkg, csc_front, csc_fifo, csc_back
`timescale 1ns / 1ps

// usage:
// items enter on in_data_i under in_valid_i / in_stall_o; results leave on
// out_data_o under out_valid_o / out_stall_i. a word moves when valid is high
// and stall is low. loads, entry reads and column end reads give one result
// each; operation 3 is dropped.
// the front classifies words into a four deep queue, so up to four words are
// taken in while the back is busy or the output is stalled; then in_stall_o rises.
// loads: one command per cycle while the output is not stalled. a read holds
// the back in a wait state until its result is registered, so no command is
// taken meanwhile (registered memory read before the result register).
// a load marked last starts the transpose pass in the back: it clears all
// 1024 column counts, counts the entries per column, forms the running sum
// per column and scatters the entries into the transposed store;
// commands wait in the queue meanwhile and the input stalls once it is full.
// reset clears the entry count and the done flag and sets both size
// registers to 1024; stores need no clearing pass.
// a stalled output holds its word; the back takes no new command until the
// result register frees up.

module csr_to_csc_transpose_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  csc_pkg::in_t              in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output csc_pkg::out_t             out_data_o,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_index_i,
  input  logic [csc_pkg::CFG_W-1:0] cfg_data_i
);

  logic          q_full, q_push, q_pop, q_valid;
  csc_pkg::cmd_t q_wdata, q_rdata;

  csc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_data_o    (q_wdata)
  );

  csc_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_rdata)
  );

  csc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_rdata),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
